// ===== sv/tmp_pkg.sv =====
// tmp_pkg: shared types and constants for the trapezoid motion profile block
// request and result structs, field widths, register indexes and reset values
// no dependencies
package tmp_pkg;

    localparam int POS_W    = 31;
    localparam int VEL_W    = 32;
    localparam int RAMP_W   = 24;
    localparam int DIVW     = 55;
    localparam int SQ_W     = 48;
    localparam int SQ_STEPS = 24;
    localparam int LIM_W    = 56;
    localparam int ACC_W    = 58;

    localparam logic [POS_W-1:0]  POS_MAX  = '1;
    localparam logic [VEL_W-1:0]  VEL_MAX  = '1;
    localparam logic [VEL_W-1:0]  VEL_RST  = 32'd65536;
    localparam logic [RAMP_W-1:0] RAMP_RST = 24'd1000;
    localparam logic [VEL_W-1:0]  ACCEL_RST = 32'(65536 / 1000);

    localparam logic CFG_MAX_VEL = 1'b0;
    localparam logic CFG_RAMP    = 1'b1;

    localparam logic ACT_SETPOINT = 1'b0;
    localparam logic ACT_TIME     = 1'b1;

    typedef struct packed {
        logic              action;
        logic [31:0]       time_now;
        logic [POS_W-1:0]  target;
    } req_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [VEL_W-1:0]  velocity;
        logic              done_res;
    } res_t;

endpackage

// ===== sv/trapezoid_motion_profile.sv =====
// trapezoid_motion_profile: trapezoidal velocity profile generator, Q16.16 fixed point
// one sequencer around a bit-serial multiplier, a restoring divider and a square root
// depends on tmp_pkg
//
// time update: two serial multiplies while ramping, one while cruising, none once done;
// each multiply steps over MB = max(TIME_WIDTH, 24) multiplier bits
// setpoint: a 55-bit divide; a triangle then adds a multiply, a divide and a 24-bit root
// register write: busy (load plus accel rate divide) before the next request
// one request at a time; rst_n resets all state, accel rate resets to 65
module trapezoid_motion_profile
    import tmp_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int TW      = TIME_WIDTH;
    localparam int MB      = (TW > RAMP_W) ? TW : RAMP_W;
    localparam int W       = ((TW > 32) ? TW : 32) + 1;
    localparam int CNT_MAX = (MB > DIVW) ? MB : DIVW;
    localparam int CW      = $clog2(CNT_MAX);
    localparam logic [W-1:0] TMAX_W = {{(W-TW){1'b0}}, {TW{1'b1}}};

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_ACC_LD  = 5'd1;
    localparam logic [4:0] ST_ACC_DIV = 5'd2;
    localparam logic [4:0] ST_SP_DIV1 = 5'd3;
    localparam logic [4:0] ST_SP_CMP  = 5'd4;
    localparam logic [4:0] ST_SP_MUL  = 5'd5;
    localparam logic [4:0] ST_SP_LD2  = 5'd6;
    localparam logic [4:0] ST_SP_DIV2 = 5'd7;
    localparam logic [4:0] ST_SP_LDS  = 5'd8;
    localparam logic [4:0] ST_SP_SQRT = 5'd9;
    localparam logic [4:0] ST_DUR1    = 5'd10;
    localparam logic [4:0] ST_DUR2    = 5'd11;
    localparam logic [4:0] ST_DUR3    = 5'd12;
    localparam logic [4:0] ST_TU_EL   = 5'd13;
    localparam logic [4:0] ST_TU_SEL  = 5'd14;
    localparam logic [4:0] ST_TU_VMUL = 5'd15;
    localparam logic [4:0] ST_TU_VSET = 5'd16;
    localparam logic [4:0] ST_TU_LDS  = 5'd17;
    localparam logic [4:0] ST_TU_SMUL = 5'd18;
    localparam logic [4:0] ST_TU_ADD  = 5'd19;
    localparam logic [4:0] ST_OUT     = 5'd20;

    function automatic logic [TW-1:0] sat_t(input logic [W-1:0] x);
        return (x > TMAX_W) ? TMAX_W[TW-1:0] : x[TW-1:0];
    endfunction

    logic [4:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg;

    logic [VEL_W-1:0]  max_vel_reg;
    logic [RAMP_W-1:0] ramp_ticks_reg;
    logic [VEL_W-1:0]  accel_reg;
    logic [TW-1:0]     start_reg, last_reg, now_reg;
    logic [TW-1:0]     ae_reg, de_reg, fin_reg, el_reg, dt_reg;
    logic [POS_W-1:0]  pos_reg, goal_reg, tgt_reg, cruise_reg;
    logic [VEL_W-1:0]  vel_reg;
    logic              done_reg;
    logic [RAMP_W-1:0] ramp_reg;

    logic [DIVW-1:0]   dq_reg, dq_next;
    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       div_d_reg;
    logic [32:0]       div_trial;
    logic              div_ge;

    logic [MB-1:0]     mb_reg;
    logic [VEL_W-1:0]  mul_a_reg;
    logic [LIM_W-1:0]  lim_reg, mul_res;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              sat_reg, sat_next;

    logic [SQ_W-1:0]   sx_reg;
    logic [26:0]       srem_reg, srem_next, sq_rt, sq_trial;
    logic [23:0]       root_reg, root_next;
    logic              sq_ge;

    logic              res_valid_reg;
    res_t              res_reg;

    logic [RAMP_W-1:0] eff_ramp;
    logic [VEL_W-1:0]  eff_vel;
    logic [TW-1:0]     el_now, lel_now, into, left;
    logic [POS_W:0]    pos_sum;
    logic              req_acc, out_go, last_step;

    assign eff_ramp  = (ramp_ticks_reg == '0) ? RAMP_W'(1) : ramp_ticks_reg;
    assign eff_vel   = (max_vel_reg == '0) ? VEL_W'(1) : max_vel_reg;
    assign req_ready = (state_reg == ST_IDLE) && !cfg_we;
    assign req_acc   = req_valid && req_ready;
    assign out_go    = (state_reg == ST_OUT) && (!res_valid_reg || res_ready);
    assign last_step = (cnt_reg == '0);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // divider step
    assign div_trial = {rem_reg, dq_reg[DIVW-1]};
    assign div_ge    = div_trial >= {1'b0, div_d_reg};
    assign rem_next  = div_ge ? 32'(div_trial - {1'b0, div_d_reg}) : div_trial[31:0];
    assign dq_next   = {dq_reg[DIVW-2:0], div_ge};

    // multiplier step, msb first, sticky saturation
    assign acc_next = {acc_reg[ACC_W-2:0], 1'b0}
                    + (mb_reg[MB-1] ? ACC_W'(mul_a_reg) : ACC_W'(0));
    assign sat_next = sat_reg || (acc_next > ACC_W'(lim_reg));
    assign mul_res  = sat_reg ? lim_reg : acc_reg[LIM_W-1:0];

    // square root step, two bits per cycle
    assign sq_rt     = {srem_reg[24:0], sx_reg[SQ_W-1:SQ_W-2]};
    assign sq_trial  = {1'b0, root_reg, 2'b01};
    assign sq_ge     = sq_rt >= sq_trial;
    assign srem_next = sq_ge ? (sq_rt - sq_trial) : sq_rt;
    assign root_next = {root_reg[22:0], sq_ge};

    assign el_now  = now_reg - start_reg;
    assign lel_now = last_reg - start_reg;
    assign into    = el_reg - de_reg;
    assign left    = (ae_reg > into) ? (ae_reg - into) : '0;
    assign pos_sum = {1'b0, pos_reg} + {1'b0, mul_res[POS_W-1:0]};

    always_comb
    begin
        state_next = state_reg;
        priority if (cfg_we)
        begin
            state_next = ST_ACC_LD;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_next = (req.action == ACT_SETPOINT) ? ST_SP_DIV1 : ST_TU_EL;
                    end
                end
                ST_ACC_LD:  state_next = ST_ACC_DIV;
                ST_ACC_DIV: state_next = last_step ? ST_IDLE : ST_ACC_DIV;
                ST_SP_DIV1: state_next = last_step ? ST_SP_CMP : ST_SP_DIV1;
                ST_SP_CMP:
                begin
                    state_next = (dq_reg[POS_W-1:0] < POS_W'(eff_ramp)) ? ST_SP_MUL : ST_DUR1;
                end
                ST_SP_MUL:  state_next = last_step ? ST_SP_LD2 : ST_SP_MUL;
                ST_SP_LD2:  state_next = ST_SP_DIV2;
                ST_SP_DIV2: state_next = last_step ? ST_SP_LDS : ST_SP_DIV2;
                ST_SP_LDS:  state_next = ST_SP_SQRT;
                ST_SP_SQRT: state_next = last_step ? ST_DUR1 : ST_SP_SQRT;
                ST_DUR1:    state_next = ST_DUR2;
                ST_DUR2:    state_next = ST_DUR3;
                ST_DUR3:    state_next = ST_OUT;
                ST_TU_EL:   state_next = ST_TU_SEL;
                ST_TU_SEL:
                begin
                    priority if (el_reg < ae_reg)  state_next = ST_TU_VMUL;
                    else if (el_reg < de_reg)      state_next = ST_TU_LDS;
                    else if (el_reg < fin_reg)     state_next = ST_TU_VMUL;
                    else                           state_next = ST_OUT;
                end
                ST_TU_VMUL: state_next = last_step ? ST_TU_VSET : ST_TU_VMUL;
                ST_TU_VSET: state_next = ST_TU_LDS;
                ST_TU_LDS:  state_next = ST_TU_SMUL;
                ST_TU_SMUL: state_next = last_step ? ST_TU_ADD : ST_TU_SMUL;
                ST_TU_ADD:  state_next = ST_OUT;
                ST_OUT:     state_next = out_go ? ST_IDLE : ST_OUT;
                default:    state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            max_vel_reg    <= VEL_RST;
            ramp_ticks_reg <= RAMP_RST;
            accel_reg      <= ACCEL_RST;
            start_reg      <= '0;
            last_reg       <= '0;
            now_reg        <= '0;
            ae_reg         <= '0;
            de_reg         <= '0;
            fin_reg        <= '0;
            el_reg         <= '0;
            dt_reg         <= '0;
            pos_reg        <= '0;
            goal_reg       <= '0;
            tgt_reg        <= '0;
            cruise_reg     <= '0;
            vel_reg        <= '0;
            done_reg       <= 1'b0;
            ramp_reg       <= '0;
            dq_reg         <= '0;
            rem_reg        <= '0;
            div_d_reg      <= '0;
            mb_reg         <= '0;
            mul_a_reg      <= '0;
            lim_reg        <= '0;
            acc_reg        <= '0;
            sat_reg        <= 1'b0;
            sx_reg         <= '0;
            srem_reg       <= '0;
            root_reg       <= '0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_go)
            begin
                res_valid_reg    <= 1'b1;
                res_reg.position <= pos_reg;
                res_reg.velocity <= vel_reg;
                res_reg.done_res <= done_reg;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_VEL: max_vel_reg    <= cfg_data;
                    CFG_RAMP:    ramp_ticks_reg <= cfg_data[RAMP_W-1:0];
                    default:     max_vel_reg    <= cfg_data;
                endcase
                goal_reg <= '0;
                vel_reg  <= '0;
            end
            else
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                        if (req_valid)
                        begin
                            now_reg  <= TW'(req.time_now);
                            done_reg <= 1'b0;
                            if (req.action == ACT_SETPOINT)
                            begin
                                goal_reg  <= req.target;
                                tgt_reg   <= req.target;
                                pos_reg   <= '0;
                                vel_reg   <= '0;
                                start_reg <= TW'(req.time_now);
                                last_reg  <= TW'(req.time_now);
                                dq_reg    <= DIVW'(req.target);
                                div_d_reg <= eff_vel;
                                rem_reg   <= '0;
                                cnt_reg   <= CW'(DIVW - 1);
                            end
                        end
                    end
                    ST_ACC_LD:
                    begin
                        dq_reg    <= DIVW'(max_vel_reg);
                        div_d_reg <= 32'(eff_ramp);
                        rem_reg   <= '0;
                        cnt_reg   <= CW'(DIVW - 1);
                    end
                    ST_ACC_DIV, ST_SP_DIV1, ST_SP_DIV2:
                    begin
                        dq_reg  <= dq_next;
                        rem_reg <= rem_next;
                        cnt_reg <= cnt_reg - CW'(1);
                        if (state_reg == ST_ACC_DIV && last_step)
                        begin
                            accel_reg <= dq_next[VEL_W-1:0];
                        end
                    end
                    ST_SP_CMP:
                    begin
                        if (dq_reg[POS_W-1:0] < POS_W'(eff_ramp))
                        begin
                            mul_a_reg <= VEL_W'(tgt_reg);
                            mb_reg    <= MB'(eff_ramp);
                            lim_reg   <= '1;
                            acc_reg   <= '0;
                            sat_reg   <= 1'b0;
                            cnt_reg   <= CW'(MB - 1);
                        end
                        else
                        begin
                            ramp_reg   <= eff_ramp;
                            cruise_reg <= dq_reg[POS_W-1:0] - POS_W'(eff_ramp);
                        end
                    end
                    ST_SP_MUL, ST_TU_VMUL, ST_TU_SMUL:
                    begin
                        acc_reg <= acc_next;
                        sat_reg <= sat_next;
                        mb_reg  <= {mb_reg[MB-2:0], 1'b0};
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                    ST_SP_LD2:
                    begin
                        dq_reg    <= mul_res[DIVW-1:0];
                        div_d_reg <= eff_vel;
                        rem_reg   <= '0;
                        cnt_reg   <= CW'(DIVW - 1);
                    end
                    ST_SP_LDS:
                    begin
                        sx_reg   <= dq_reg[SQ_W-1:0];
                        srem_reg <= '0;
                        root_reg <= '0;
                        cnt_reg  <= CW'(SQ_STEPS - 1);
                    end
                    ST_SP_SQRT:
                    begin
                        sx_reg   <= {sx_reg[SQ_W-3:0], 2'b00};
                        srem_reg <= srem_next;
                        root_reg <= root_next;
                        cnt_reg  <= cnt_reg - CW'(1);
                        if (last_step)
                        begin
                            ramp_reg   <= root_next;
                            cruise_reg <= '0;
                        end
                    end
                    ST_DUR1:
                    begin
                        ae_reg <= sat_t(W'(ramp_reg));
                        de_reg <= sat_t(W'(cruise_reg));
                    end
                    ST_DUR2: de_reg  <= sat_t(W'(ae_reg) + W'(de_reg));
                    ST_DUR3: fin_reg <= sat_t(W'(de_reg) + W'(ae_reg));
                    ST_TU_EL:
                    begin
                        el_reg   <= el_now;
                        dt_reg   <= (el_now >= lel_now) ? (el_now - lel_now) : '0;
                        last_reg <= now_reg;
                    end
                    ST_TU_SEL:
                    begin
                        mul_a_reg <= accel_reg;
                        lim_reg   <= LIM_W'(VEL_MAX);
                        acc_reg   <= '0;
                        sat_reg   <= 1'b0;
                        cnt_reg   <= CW'(MB - 1);
                        priority if (el_reg < ae_reg)
                        begin
                            mb_reg <= MB'(el_reg);
                        end
                        else if (el_reg < de_reg)
                        begin
                            vel_reg <= max_vel_reg;
                        end
                        else if (el_reg < fin_reg)
                        begin
                            mb_reg <= MB'(left);
                        end
                        else
                        begin
                            vel_reg  <= '0;
                            pos_reg  <= goal_reg;
                            done_reg <= 1'b1;
                        end
                    end
                    ST_TU_VSET: vel_reg <= mul_res[VEL_W-1:0];
                    ST_TU_LDS:
                    begin
                        mul_a_reg <= vel_reg;
                        mb_reg    <= MB'(dt_reg);
                        lim_reg   <= LIM_W'(POS_MAX);
                        acc_reg   <= '0;
                        sat_reg   <= 1'b0;
                        cnt_reg   <= CW'(MB - 1);
                    end
                    ST_TU_ADD:
                    begin
                        pos_reg <= pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
                    end
                    default:
                    begin
                        cnt_reg <= cnt_reg;
                    end
                endcase
            end
        end
    end

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && res_valid_reg && !res_ready) |=> (state_reg == ST_OUT))
        else $error("finished result lost while output stalled");

    a_req_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start work");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (state_reg == ST_ACC_LD && vel_reg == '0 && goal_reg == '0))
        else $error("register write did not restart accel rate");

    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SP_CMP) |-> (dq_reg[DIVW-1:POS_W] == '0))
        else $error("target quotient out of range");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req_ready)
        else $error("request taken while busy");

endmodule

// ===== tb/tb_trapezoid_motion_profile.sv =====
// tb_trapezoid_motion_profile: self-checking testbench for the trapezoid motion profile block
// directed table then random move sequences over several register settings, scoreboard on results
// depends on tmp_pkg and trapezoid_motion_profile
`timescale 1ns / 1ps

module tb_trapezoid_motion_profile;
    import tmp_pkg::*;

    localparam longint unsigned TMASK  = 64'hFFFF_FFFF;
    localparam longint unsigned PLIM   = 64'h7FFF_FFFF;
    localparam longint unsigned VLIM   = 64'hFFFF_FFFF;
    localparam int              CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        res_valid;
    logic        res_ready;
    res_t        res;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    trapezoid_motion_profile i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // profile model state
    longint unsigned vmax, ramp_cfg;
    longint unsigned move_start, prev_time, pos, vel, goal_pos, accel;
    longint unsigned ramp_dur, decel_at, finish_at;

    res_t expected_q[$];
    int   mismatches;
    int   burst_left;
    bit   hold_trigger;
    int   hold_left;
    int   stall_mode;
    int   cycles;

    typedef struct {
        req_t r;
        bit   typed;
        res_t e;
    } row_t;

    row_t dir_rows[$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint unsigned sat_mul(longint unsigned a, longint unsigned b,
                                                longint unsigned lim);
        if (a == 0 || b == 0) return 0;
        if (a > lim / b) return lim;
        return a * b;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned tsat(longint unsigned t);
        return (t > TMASK) ? TMASK : t;
    endfunction

    function automatic void set_profile_reg(logic idx, logic [31:0] val);
        if (idx == CFG_MAX_VEL) vmax = val;
        else ramp_cfg = val[23:0];
        accel = vmax / ((ramp_cfg != 0) ? ramp_cfg : 1);
        goal_pos = 0;
        vel = 0;
    endfunction

    function automatic res_t profile_step(req_t r);
        longint unsigned now, t, vd, rd, cr, el, last_el, dt, into, left;
        bit done;
        bit moving;
        res_t o;
        now = r.time_now;
        done = 0;
        if (r.action == ACT_SETPOINT) begin
            t = (ramp_cfg != 0) ? ramp_cfg : 1;
            vd = (vmax != 0) ? vmax : 1;
            goal_pos = r.target;
            pos = 0;
            vel = 0;
            move_start = now;
            prev_time = now;
            if (goal_pos < t * vd) begin
                rd = floor_sqrt((goal_pos * t) / vd);
                cr = 0;
            end
            else begin
                rd = t;
                cr = goal_pos / vd - t;
            end
            ramp_dur = tsat(rd);
            decel_at = tsat(ramp_dur + tsat(cr));
            finish_at = tsat(decel_at + ramp_dur);
        end
        else begin
            el = (now - move_start) & TMASK;
            last_el = (prev_time - move_start) & TMASK;
            dt = (el >= last_el) ? el - last_el : 0;
            moving = 1;
            if (el < ramp_dur)
                vel = sat_mul(accel, el, VLIM);
            else if (el < decel_at)
                vel = vmax;
            else if (el < finish_at) begin
                into = el - decel_at;
                left = (ramp_dur > into) ? ramp_dur - into : 0;
                vel = sat_mul(accel, left, VLIM);
            end
            else begin
                moving = 0;
                vel = 0;
                pos = goal_pos;
                done = 1;
            end
            if (moving) begin
                pos += sat_mul(vel, dt, PLIM);
                if (pos > PLIM) pos = PLIM;
            end
            prev_time = now;
        end
        o.position = pos[30:0];
        o.velocity = vel[31:0];
        o.done_res = done;
        return o;
    endfunction

    // request side: bursts with random gaps
    task automatic send_request(req_t r, bit typed, res_t e);
        res_t p;
        if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
        burst_left--;
        p = profile_step(r);
        expected_q.push_back(typed ? e : p);
    endtask

    task automatic drain_and_idle();
        req_valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_profile_reg(logic idx, logic [31:0] val);
        drain_and_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        set_profile_reg(idx, val);
    endtask

    task automatic run_moves(int n_items);
        req_t r;
        res_t z;
        longint unsigned span, t0;
        int cnt, k, m;
        z = '0;
        cnt = 0;
        while (cnt < n_items) begin
            r.action = ACT_SETPOINT;
            r.time_now = $urandom;
            m = $urandom_range(0, 3);
            if (m == 0) r.target = 31'($urandom);
            else if (m == 1) r.target = 31'($urandom_range(0, 1 << 20));
            else if (m == 2) r.target = 31'(vmax * ramp_cfg + $urandom_range(0, 2) - 1);
            else r.target = 31'($urandom_range(0, 1 << 26));
            t0 = r.time_now;
            send_request(r, 1'b0, z);
            cnt++;
            span = finish_at + finish_at / 4 + 2;
            if (span > TMASK) span = TMASK;
            k = $urandom_range(3, 8);
            for (int i = 1; i <= k; i++) begin
                r.action = ACT_TIME;
                if ($urandom_range(0, 9) == 0) r.time_now = $urandom;
                else r.time_now = 32'(t0 + (span * i) / k + $urandom_range(0, 3));
                r.target = 31'($urandom);
                send_request(r, 1'b0, z);
                cnt++;
            end
        end
    endtask

    function automatic row_t mk(logic act, logic [31:0] tn, logic [30:0] tg, bit typed,
                                logic [30:0] ep, logic [31:0] ev, logic ed);
        row_t w;
        w.r.action = act;
        w.r.time_now = tn;
        w.r.target = tg;
        w.typed = typed;
        w.e.position = ep;
        w.e.velocity = ev;
        w.e.done_res = ed;
        return w;
    endfunction

    // result side: stall pattern plus long hold-off
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
            hold_left <= 0;
            stall_mode <= 0;
        end
        else begin
            if (res_valid && res_ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", res);
                end
                else begin
                    res_t e;
                    e = expected_q.pop_front();
                    if (res.position !== e.position || res.velocity !== e.velocity
                        || res.done_res !== e.done_res) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp pos %h vel %h done %b, got pos %h vel %h done %b",
                                     e.position, e.velocity, e.done_res,
                                     res.position, res.velocity, res.done_res);
                    end
                end
            end
            if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 2);
            if (hold_trigger) begin
                hold_trigger = 1'b0;
                hold_left <= 600;
                res_ready <= 1'b0;
            end
            else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                res_ready <= 1'b0;
            end
            else if (stall_mode == 0)
                res_ready <= 1'b1;
            else if (stall_mode == 1)
                res_ready <= 1'($urandom_range(0, 1));
            else
                res_ready <= (cycles % 4 == 0);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("trapezoid_motion_profile regression: fail");
            $finish;
        end
    end

    initial begin
        res_t z;
        z = '0;
        cycles = 0;
        mismatches = 0;
        burst_left = 0;
        hold_trigger = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_MAX_VEL;
        cfg_data = '0;
        vmax = VEL_RST;
        ramp_cfg = RAMP_RST;
        accel = ACCEL_RST;
        move_start = 0;
        prev_time = 0;
        pos = 0;
        vel = 0;
        goal_pos = 0;
        ramp_dur = 0;
        decel_at = 0;
        finish_at = 0;

        // reset config: V 65536, T 1000
        dir_rows.push_back(mk(ACT_SETPOINT, 32'd0, 31'd0, 1, 0, 0, 0));
        dir_rows.push_back(mk(ACT_TIME, 32'd5, 31'd0, 1, 0, 0, 1));
        dir_rows.push_back(mk(ACT_SETPOINT, 32'd100, POS_MAX, 1, 0, 0, 0));
        dir_rows.push_back(mk(ACT_TIME, 32'd600, 31'd0, 0, 0, 0, 0));
        dir_rows.push_back(mk(ACT_TIME, 32'd300, 31'd0, 0, 0, 0, 0));
        dir_rows.push_back(mk(ACT_TIME, 32'd20000, 31'd0, 0, 0, 0, 0));
        dir_rows.push_back(mk(ACT_TIME, 32'd33000, 31'd0, 0, 0, 0, 0));
        dir_rows.push_back(mk(ACT_TIME, 32'd34000, POS_MAX, 1, POS_MAX, 0, 1));
        dir_rows.push_back(mk(ACT_SETPOINT, 32'hFFFF_FFF0, 31'd1000000, 1, 0, 0, 0));
        dir_rows.push_back(mk(ACT_TIME, 32'h0000_0010, 31'd0, 0, 0, 0, 0));
        dir_rows.push_back(mk(ACT_TIME, 32'h0000_0100, 31'd0, 0, 0, 0, 0));
        dir_rows.push_back(mk(ACT_TIME, 32'hFFFF_FF00, 31'd0, 1, 31'd1000000, 0, 1));
        dir_rows.push_back(mk(ACT_SETPOINT, 32'd50, 31'd65536000, 1, 0, 0, 0));
        dir_rows.push_back(mk(ACT_TIME, 32'd1049, 31'd0, 0, 0, 0, 0));
        dir_rows.push_back(mk(ACT_TIME, 32'd1500, 31'd0, 0, 0, 0, 0));
        dir_rows.push_back(mk(ACT_TIME, 32'hFFFF_FFFF, 31'd0, 1, 31'd65536000, 0, 1));
        dir_rows.push_back(mk(ACT_SETPOINT, 32'hFFFF_FFFF, 31'd1, 1, 0, 0, 0));
        dir_rows.push_back(mk(ACT_TIME, 32'd0, 31'd0, 0, 0, 0, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);

        run_moves(60);
        hold_trigger = 1'b1;
        run_moves(30);

        write_profile_reg(CFG_MAX_VEL, 32'd0);
        run_moves(40);
        write_profile_reg(CFG_RAMP, 32'd0);
        run_moves(40);
        write_profile_reg(CFG_MAX_VEL, 32'hFFFF_FFFF);
        run_moves(40);
        write_profile_reg(CFG_RAMP, 32'hFF_FFFF);
        run_moves(40);
        write_profile_reg(CFG_MAX_VEL, 32'd1);
        run_moves(30);
        write_profile_reg(CFG_MAX_VEL, $urandom);
        write_profile_reg(CFG_RAMP, $urandom_range(1, 5000));
        run_moves(60);
        write_profile_reg(CFG_MAX_VEL, $urandom_range(1, 1 << 20));
        write_profile_reg(CFG_RAMP, $urandom_range(1, 100));
        hold_trigger = 1'b1;
        run_moves(60);

        drain_and_idle();
        repeat (150) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("trapezoid_motion_profile regression: pass");
        else
            $display("trapezoid_motion_profile regression: fail");
        $finish;
    end

endmodule
